>>> rtl/smce_pkg.sv
// Package for the servo move command encoder.
// Holds the constants, register indexes, frame characters and control structs.
// No dependencies.
`timescale 1ns / 1ps
package smce_pkg;

    localparam int MAX_ID           = 254;
    localparam int PULSE_LIMIT_LOW  = 500;
    localparam int PULSE_LIMIT_HIGH = 2500;
    localparam int TIME_LIMIT_MS    = 9999;
    localparam int SERVO_SLOTS      = 256;
    localparam int SLOT_W           = $clog2(SERVO_SLOTS);

    localparam int IN_DATA_W = 72;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int DIV_W     = 32;
    localparam int DVS_W     = 17;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR       = 3'd6;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [3:0] LAST_BYTE = 4'd14;
    localparam logic [3:0] LAST_DIGIT_STEP = 4'd3;

    typedef struct packed {
        logic       load_in;
        logic       step_load;
        logic       step_mul1;
        logic       step_mul2;
        logic       div_start;
        logic       step_fin;
        logic       conv_step;
        logic       out_load;
        logic       out_fault;
        logic [3:0] byte_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bad_id;
        logic div_busy;
        logic out_free;
    } ctrl_sts_t;

endpackage

>>> rtl/smce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module smce_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/smce_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on smce_pkg.
`timescale 1ns / 1ps
module smce_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [smce_pkg::DIV_W-1:0] dividend,
    input  logic [smce_pkg::DVS_W-1:0] divisor,
    output logic [smce_pkg::DIV_W-1:0] quotient,
    output logic                       busy
);
    import smce_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] dq_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            dq_reg  <= {dq_reg[DIV_W-2:0], ge};
        end
    end

    assign quotient = dq_reg;
    assign busy     = cnt_reg != '0;

endmodule

>>> rtl/smce_dp.sv
// Datapath: config registers, angle store, pulse and time arithmetic, digits, output register.
// Depends on smce_pkg, smce_ram and smce_div.
`timescale 1ns / 1ps
module smce_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  smce_pkg::ctrl_cmd_t            cmd,
    output smce_pkg::ctrl_sts_t            sts,
    input  logic [smce_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_valid,
    input  logic [smce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smce_pkg::CFG_DAT_W-1:0] cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import smce_pkg::*;

    logic signed [12:0] amin_reg, acen_reg, amax_reg;
    logic [11:0]        pmin_reg, pcen_reg, pmax_reg;
    logic               mirror_reg;

    logic               cmd_reg;
    logic [7:0]         id_reg;
    logic signed [12:0] tgt_reg;
    logic signed [15:0] spd_reg;
    logic [15:0]        rawp_reg, rawt_reg;

    logic signed [12:0] a_reg;
    logic signed [13:0] da_reg;
    logic signed [12:0] dp_reg;
    logic [11:0]        base_reg;
    logic [12:0]        den_reg;
    logic               neg_reg, zero_reg;
    logic [15:0]        mag_reg;

    logic signed [27:0] num_reg;
    logic [24:0]        base_den_reg;
    logic [25:0]        mir_den_reg;
    logic [12:0]        delta_reg;

    logic               n_neg_reg;
    logic [DIV_W-1:0]   n_mag_reg;
    logic [DIV_W-1:0]   tnum_reg;

    logic [13:0]        idv_reg, pv_reg, tv_reg;
    logic [3:0][3:0]    idd_reg, pd_reg, td_reg;

    logic               out_valid_reg, out_last_reg, out_fault_reg;
    logic [7:0]         out_byte_reg;

    logic [SERVO_SLOTS-1:0] known_reg;
    logic [12:0]            ram_q;
    logic                   ram_we;
    logic [DIV_W-1:0]       qp, qt;
    logic                   busy_p, busy_t;

    logic signed [12:0] a_c;
    logic               hi;
    logic signed [13:0] den_raw;
    logic signed [16:0] spd_ext;
    logic signed [26:0] prod;
    logic signed [12:0] ref_a;
    logic signed [13:0] dref;
    logic signed [29:0] total0, total;
    logic signed [31:0] n_val;
    logic [15:0]        pclamp_raw;
    logic [13:0]        pfin, tfin;
    logic [3:0]         idg, pdg, tdg;
    logic [13:0]        idq, pq, tq;
    logic [7:0]         byte_sel;

    function automatic logic [13:0] div10(input logic [13:0] v);
        logic [29:0] p;
        p = v * 16'd52429;
        return {3'b0, p[29:19]};
    endfunction

    function automatic logic [3:0] digit(input logic [13:0] v, input logic [13:0] q);
        logic [13:0] r;
        r = v - 14'(q * 4'd10);
        return r[3:0];
    endfunction

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amin_reg   <= -13'sd2356;
            acen_reg   <= 13'sd0;
            amax_reg   <= 13'sd2356;
            pmin_reg   <= 12'd500;
            pcen_reg   <= 12'd1500;
            pmax_reg   <= 12'd2500;
            mirror_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ANGLE_MIN:    amin_reg   <= cfg_data;
                REG_ANGLE_CENTER: acen_reg   <= cfg_data;
                REG_ANGLE_MAX:    amax_reg   <= cfg_data;
                REG_PULSE_MIN:    pmin_reg   <= cfg_data[11:0];
                REG_PULSE_CENTER: pcen_reg   <= cfg_data[11:0];
                REG_PULSE_MAX:    pmax_reg   <= cfg_data[11:0];
                REG_MIRROR:       mirror_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // load stage
    always_comb
    begin
        if (tgt_reg < amin_reg)
        begin
            a_c = amin_reg;
        end
        else if (tgt_reg > amax_reg)
        begin
            a_c = amax_reg;
        end
        else
        begin
            a_c = tgt_reg;
        end
        hi      = a_c >= acen_reg;
        den_raw = hi ? {amax_reg[12], amax_reg} - {acen_reg[12], acen_reg}
                     : {acen_reg[12], acen_reg} - {amin_reg[12], amin_reg};
        spd_ext = {spd_reg[15], spd_reg};
    end

    assign prod  = da_reg * dp_reg;
    assign ref_a = known_reg[id_reg[SLOT_W-1:0]] ? $signed(ram_q) : acen_reg;
    assign dref  = {a_reg[12], a_reg} - {ref_a[12], ref_a};

    always_comb
    begin
        total0 = $signed({5'b0, base_den_reg}) + 30'(num_reg);
        total  = mirror_reg ? $signed({4'b0, mir_den_reg}) - total0 : total0;
        n_val  = $signed({total[29], total, 1'b0}) + $signed({19'b0, den_reg});
    end

    assign pclamp_raw = (rawp_reg < 16'(PULSE_LIMIT_LOW)) ? 16'(PULSE_LIMIT_LOW)
                      : (rawp_reg > 16'(PULSE_LIMIT_HIGH)) ? 16'(PULSE_LIMIT_HIGH) : rawp_reg;

    always_comb
    begin
        if (cmd_reg)
        begin
            pfin = pclamp_raw[13:0];
            tfin = (rawt_reg > 16'(TIME_LIMIT_MS)) ? 14'(TIME_LIMIT_MS) : rawt_reg[13:0];
        end
        else
        begin
            if (n_neg_reg || qp < DIV_W'(PULSE_LIMIT_LOW))
            begin
                pfin = 14'(PULSE_LIMIT_LOW);
            end
            else if (qp > DIV_W'(PULSE_LIMIT_HIGH))
            begin
                pfin = 14'(PULSE_LIMIT_HIGH);
            end
            else
            begin
                pfin = qp[13:0];
            end
            if (mag_reg == '0)
            begin
                tfin = '0;
            end
            else if (qt > DIV_W'(TIME_LIMIT_MS))
            begin
                tfin = 14'(TIME_LIMIT_MS);
            end
            else
            begin
                tfin = qt[13:0];
            end
        end
    end

    assign idq = div10(idv_reg);
    assign pq  = div10(pv_reg);
    assign tq  = div10(tv_reg);
    assign idg = digit(idv_reg, idq);
    assign pdg = digit(pv_reg, pq);
    assign tdg = digit(tv_reg, tq);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= s_tuser;
            id_reg   <= s_tdata[7:0];
            tgt_reg  <= s_tdata[20:8];
            spd_reg  <= s_tdata[36:21];
            rawp_reg <= s_tdata[52:37];
            rawt_reg <= s_tdata[68:53];
        end
        if (cmd.step_load)
        begin
            a_reg    <= a_c;
            da_reg   <= hi ? {a_c[12], a_c} - {acen_reg[12], acen_reg}
                           : {a_c[12], a_c} - {amin_reg[12], amin_reg};
            dp_reg   <= hi ? $signed({1'b0, pmax_reg}) - $signed({1'b0, pcen_reg})
                           : $signed({1'b0, pcen_reg}) - $signed({1'b0, pmin_reg});
            base_reg <= hi ? pcen_reg : pmin_reg;
            zero_reg <= den_raw == '0;
            neg_reg  <= den_raw < 0;
            den_reg  <= (den_raw == '0) ? 13'd1
                      : (den_raw < 0) ? 13'(-den_raw) : den_raw[12:0];
            mag_reg  <= spd_ext < 0 ? 16'(-spd_ext) : spd_reg;
        end
        if (cmd.step_mul1)
        begin
            num_reg      <= zero_reg ? '0 : neg_reg ? -28'(prod) : 28'(prod);
            base_den_reg <= base_reg * den_reg;
            mir_den_reg  <= ({1'b0, pmin_reg} + {1'b0, pmax_reg}) * den_reg;
            delta_reg    <= dref < 0 ? 13'(-dref) : dref[12:0];
        end
        if (cmd.step_mul2)
        begin
            n_neg_reg <= n_val < 0;
            n_mag_reg <= n_val < 0 ? DIV_W'(-n_val) : DIV_W'(n_val);
            tnum_reg  <= DIV_W'(delta_reg) * DIV_W'(2000) + DIV_W'(mag_reg);
        end
        if (cmd.step_fin)
        begin
            idv_reg <= {6'b0, id_reg};
            pv_reg  <= pfin;
            tv_reg  <= tfin;
        end
        if (cmd.conv_step)
        begin
            idv_reg <= idq;
            pv_reg  <= pq;
            tv_reg  <= tq;
            idd_reg <= {idg, idd_reg[3:1]};
            pd_reg  <= {pdg, pd_reg[3:1]};
            td_reg  <= {tdg, td_reg[3:1]};
        end
    end

    assign ram_we = cmd.step_mul2 && !cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
        end
        else if (ram_we)
        begin
            known_reg[id_reg[SLOT_W-1:0]] <= 1'b1;
        end
    end

    smce_ram #(
        .WIDTH (13),
        .DEPTH (SERVO_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_reg[SLOT_W-1:0]),
        .wdata (a_reg),
        .raddr (id_reg[SLOT_W-1:0]),
        .rdata (ram_q)
    );

    smce_div u_div_pulse (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_mag_reg),
        .divisor  ({3'b0, den_reg, 1'b0}),
        .quotient (qp),
        .busy     (busy_p)
    );

    smce_div u_div_time (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tnum_reg),
        .divisor  ({mag_reg, 1'b0}),
        .quotient (qt),
        .busy     (busy_t)
    );

    always_comb
    begin
        case (cmd.byte_idx)
            4'd0:    byte_sel = CH_HASH;
            4'd1:    byte_sel = CH_ZERO + {4'b0, idd_reg[2]};
            4'd2:    byte_sel = CH_ZERO + {4'b0, idd_reg[1]};
            4'd3:    byte_sel = CH_ZERO + {4'b0, idd_reg[0]};
            4'd4:    byte_sel = CH_P;
            4'd5:    byte_sel = CH_ZERO + {4'b0, pd_reg[3]};
            4'd6:    byte_sel = CH_ZERO + {4'b0, pd_reg[2]};
            4'd7:    byte_sel = CH_ZERO + {4'b0, pd_reg[1]};
            4'd8:    byte_sel = CH_ZERO + {4'b0, pd_reg[0]};
            4'd9:    byte_sel = CH_T;
            4'd10:   byte_sel = CH_ZERO + {4'b0, td_reg[3]};
            4'd11:   byte_sel = CH_ZERO + {4'b0, td_reg[2]};
            4'd12:   byte_sel = CH_ZERO + {4'b0, td_reg[1]};
            4'd13:   byte_sel = CH_ZERO + {4'b0, td_reg[0]};
            default: byte_sel = CH_BANG;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_byte_reg  <= cmd.out_fault ? 8'd0 : byte_sel;
            out_last_reg  <= cmd.out_fault || cmd.byte_idx == LAST_BYTE;
            out_fault_reg <= cmd.out_fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fault_reg;

    assign sts.bad_id   = id_reg > 8'(MAX_ID) || 32'(id_reg) >= SERVO_SLOTS;
    assign sts.div_busy = busy_p || busy_t;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

>>> rtl/smce_ctrl.sv
// Controller state machine: sequences load, multiply, divide, digit and emit steps.
// Depends on smce_pkg.
`timescale 1ns / 1ps
module smce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output smce_pkg::ctrl_cmd_t  cmd,
    input  smce_pkg::ctrl_sts_t  sts
);
    import smce_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_MUL1  = 4'd2;
    localparam logic [3:0] ST_MUL2  = 4'd3;
    localparam logic [3:0] ST_DIVST = 4'd4;
    localparam logic [3:0] ST_DIVW  = 4'd5;
    localparam logic [3:0] ST_FIN   = 4'd6;
    localparam logic [3:0] ST_CONV  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;
    localparam logic [3:0] ST_FAULT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       accept;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.byte_idx  = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.step_load = 1'b1;
                state_next    = sts.bad_id ? ST_FAULT : ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.step_mul1 = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.step_mul2 = 1'b1;
                state_next    = ST_DIVST;
            end
            ST_DIVST:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.step_fin = 1'b1;
                cnt_next     = '0;
                state_next   = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (cnt_reg == LAST_DIGIT_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (cnt_reg == LAST_BYTE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_FAULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_fault = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted request did not enter load");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output loaded while occupied");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg <= LAST_BYTE)
        else $error("byte index out of frame");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> !sts.div_busy)
        else $error("result taken while divider busy");

endmodule

>>> rtl/servo_move_command_encoder.sv
// Servo move command encoder: one request in, the frame #iiiPppppTtttt! out byte by byte.
// A new request is taken only once the previous frame has been fully loaded into the output;
// the time per request is set by the two dividers run side by side, the 4 digit steps and the
// 15 emitted bytes; output stalls add to it. A bad id gives one fault byte instead of a frame.
// Reset is asynchronous, active low: config and control registers take their defaults and all stored angles
// are forgotten at once through per-servo valid flags.
`timescale 1ns / 1ps
module servo_move_command_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // servo_id[7:0], target_mrad[20:8], speed_mrad_s[36:21], raw_pulse_us[52:37],
    // raw_time_ms[68:53], zero fill
    input  logic [smce_pkg::IN_DATA_W-1:0] s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_byte
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast,
    // fault
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smce_pkg::CFG_DAT_W-1:0] cfg_data
);
    import smce_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    smce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    smce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> tb/servo_move_command_encoder_tb.sv
// Testbench for the servo move command encoder: drives move requests and register writes,
// predicts every frame byte from its own model of pulse mapping and move time, and checks it.
// Depends on smce_pkg and servo_move_command_encoder.
`timescale 1ns / 1ps
module servo_move_command_encoder_tb;
    import smce_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  servo_id;
        logic [12:0] target_mrad;
        logic [15:0] speed_mrad_s;
        logic [15:0] raw_pulse_us;
        logic [15:0] raw_time_ms;
    } move_req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       fault;
    } frame_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    servo_move_command_encoder uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    int signed   p_amin, p_acen, p_amax;
    int          p_pmin, p_pcen, p_pmax;
    bit          p_mirror;
    int signed   stored_angle [SERVO_SLOTS];
    bit          angle_seen [SERVO_SLOTS];

    move_req_t   pending_moves [$];
    frame_beat_t expected_beats [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_sink = 1'b0;
    int          sink_hold_left = 0;
    int          src_gap = 0;
    int          sink_gap = 0;

    task automatic report(input string what, input logic [9:0] got, input logic [9:0] want);
        errors++;
        $display("ERR t=%0t %s got=%h want=%h", $time, what, got, want);
    endtask

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint limit_pulse(input longint p);
        if (p < PULSE_LIMIT_LOW) return PULSE_LIMIT_LOW;
        if (p > PULSE_LIMIT_HIGH) return PULSE_LIMIT_HIGH;
        return p;
    endfunction

    function automatic longint pulse_for_angle(input int signed a);
        longint num, den, base, total;
        if (a >= p_acen)
        begin
            den = longint'(p_amax) - p_acen;
            num = (longint'(a) - p_acen) * (longint'(p_pmax) - p_pcen);
            base = p_pcen;
        end
        else
        begin
            den = longint'(p_acen) - p_amin;
            num = (longint'(a) - p_amin) * (longint'(p_pcen) - p_pmin);
            base = p_pmin;
        end
        if (den == 0)
        begin
            den = 1;
            num = 0;
        end
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        total = base * den + num;
        if (p_mirror) total = (longint'(p_pmin) + p_pmax) * den - total;
        return limit_pulse(floor_quot(2 * total + den, 2 * den));
    endfunction

    task automatic predict_frame(input move_req_t r);
        int signed a;
        longint mag, refa, delta, pulse, tms;
        byte unsigned fr [15];
        int id;
        id = int'(r.servo_id);
        if (id > MAX_ID || id >= SERVO_SLOTS)
        begin
            expected_beats.push_back('{8'h00, 1'b1, 1'b1});
            return;
        end
        if (r.cmd == 1'b0)
        begin
            a = $signed(r.target_mrad);
            mag = $signed(r.speed_mrad_s);
            if (mag < 0) mag = -mag;
            if (a < p_amin) a = p_amin;
            else if (a > p_amax) a = p_amax;
            pulse = pulse_for_angle(a);
            if (mag == 0) tms = 0;
            else
            begin
                refa = angle_seen[id] ? stored_angle[id] : p_acen;
                delta = longint'(a) - refa;
                if (delta < 0) delta = -delta;
                tms = (2000 * delta + mag) / (2 * mag);
                if (tms > TIME_LIMIT_MS) tms = TIME_LIMIT_MS;
            end
            stored_angle[id] = a;
            angle_seen[id] = 1'b1;
        end
        else
        begin
            pulse = limit_pulse(longint'(r.raw_pulse_us));
            tms = longint'(r.raw_time_ms);
            if (tms > TIME_LIMIT_MS) tms = TIME_LIMIT_MS;
        end
        fr[0] = CH_HASH;
        fr[1] = 8'(CH_ZERO + id / 100);
        fr[2] = 8'(CH_ZERO + (id / 10) % 10);
        fr[3] = 8'(CH_ZERO + id % 10);
        fr[4] = CH_P;
        fr[5] = 8'(CH_ZERO + pulse / 1000 % 10);
        fr[6] = 8'(CH_ZERO + pulse / 100 % 10);
        fr[7] = 8'(CH_ZERO + pulse / 10 % 10);
        fr[8] = 8'(CH_ZERO + pulse % 10);
        fr[9] = CH_T;
        fr[10] = 8'(CH_ZERO + tms / 1000 % 10);
        fr[11] = 8'(CH_ZERO + tms / 100 % 10);
        fr[12] = 8'(CH_ZERO + tms / 10 % 10);
        fr[13] = 8'(CH_ZERO + tms % 10);
        fr[14] = CH_BANG;
        for (int k = 0; k < 15; k++)
            expected_beats.push_back('{fr[k], k == 14, 1'b0});
    endtask

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (s_tvalid && s_tready)
            predict_frame(pending_moves.pop_front());
        if (src_gap > 0)
        begin
            src_gap <= src_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (pending_moves.size() > (s_tvalid && s_tready ? 0 : 0) &&
                 !(s_tvalid && !s_tready))
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                src_gap <= $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {3'b0, pending_moves[0].raw_time_ms, pending_moves[0].raw_pulse_us,
                            pending_moves[0].speed_mrad_s, pending_moves[0].target_mrad,
                            pending_moves[0].servo_id};
                s_tuser <= pending_moves[0].cmd;
            end
        end
        else if (!(s_tvalid && !s_tready))
            s_tvalid <= 1'b0;
    end

    // receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_sink)
            sink_hold_left <= 400;
        else if (sink_hold_left > 0)
            sink_hold_left <= sink_hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
                report("unexpected beat", {m_tdata, m_tlast, m_tuser}, 10'h0);
            else
            begin
                frame_beat_t w;
                w = expected_beats.pop_front();
                if (m_tdata !== w.frame_byte) report("frame_byte", m_tdata, w.frame_byte);
                if (m_tlast !== w.frame_end) report("frame_end", m_tlast, w.frame_end);
                if (m_tuser !== w.fault) report("fault", m_tuser, w.fault);
            end
        end
        if (hold_sink || sink_hold_left > 0)
        begin
            m_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_gap <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
        if (cycles > 800000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic move_req_t angle_move(input int id, input int a, input int s);
        move_req_t r;
        r = '0;
        r.servo_id = 8'(id);
        r.target_mrad = 13'(a);
        r.speed_mrad_s = 16'(s);
        r.raw_pulse_us = 16'($urandom);
        r.raw_time_ms = 16'($urandom);
        return r;
    endfunction

    function automatic move_req_t raw_move(input int id, input int p, input int t);
        move_req_t r;
        r = '0;
        r.cmd = 1'b1;
        r.servo_id = 8'(id);
        r.raw_pulse_us = 16'(p);
        r.raw_time_ms = 16'(t);
        r.target_mrad = 13'($urandom);
        r.speed_mrad_s = 16'($urandom);
        return r;
    endfunction

    task automatic drain();
        while (pending_moves.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ANGLE_MIN:    p_amin = $signed(CFG_DAT_W'(value));
            REG_ANGLE_CENTER: p_acen = $signed(CFG_DAT_W'(value));
            REG_ANGLE_MAX:    p_amax = $signed(CFG_DAT_W'(value));
            REG_PULSE_MIN:    p_pmin = value & 12'hFFF;
            REG_PULSE_CENTER: p_pcen = value & 12'hFFF;
            REG_PULSE_MAX:    p_pmax = value & 12'hFFF;
            REG_MIRROR:       p_mirror = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_all(input int amin, input int acen, input int amax,
                           input int pmin, input int pcen, input int pmax, input int mir);
        write_reg(REG_ANGLE_MIN, amin);
        write_reg(REG_ANGLE_CENTER, acen);
        write_reg(REG_ANGLE_MAX, amax);
        write_reg(REG_PULSE_MIN, pmin);
        write_reg(REG_PULSE_CENTER, pcen);
        write_reg(REG_PULSE_MAX, pmax);
        write_reg(REG_MIRROR, mir);
    endtask

    function automatic move_req_t random_move();
        int id;
        id = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ID + 1, 255)
                                         : $urandom_range(0, 255);
        if ($urandom_range(0, 2) == 0)
            return raw_move(id, ($urandom_range(0, 1)) ? $urandom_range(0, 3000) : $urandom,
                            ($urandom_range(0, 1)) ? $urandom_range(0, 12000) : $urandom);
        return angle_move(id, $urandom, ($urandom_range(0, 7) == 0) ? 0 :
                          ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 50)));
    endfunction

    initial
    begin
        p_amin = -2356; p_acen = 0; p_amax = 2356;
        p_pmin = 500; p_pcen = 1500; p_pmax = 2500; p_mirror = 0;
        foreach (angle_seen[i])
        begin
            angle_seen[i] = 0;
            stored_angle[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both commands, zero speed, bad id, no prior angle
        pending_moves.push_back(angle_move(0, 0, 1000));
        pending_moves.push_back(angle_move(0, -4096, 1));
        pending_moves.push_back(angle_move(0, 4095, -32768));
        pending_moves.push_back(angle_move(254, 1200, 0));
        pending_moves.push_back(angle_move(254, -1200, 32767));
        pending_moves.push_back(angle_move(7, -1, -1));
        pending_moves.push_back(raw_move(255, 1500, 100));
        pending_moves.push_back(raw_move(1, 0, 0));
        pending_moves.push_back(raw_move(1, 65535, 65535));
        pending_moves.push_back(raw_move(99, 2500, 9999));
        pending_moves.push_back(raw_move(100, 499, 10000));
        pending_moves.push_back(angle_move(255, 100, 100));
        pending_moves.push_back(angle_move(200, 2356, 3));
        drain();

        // receiver holds off while requests keep coming
        hold_sink <= 1'b1;
        for (int i = 0; i < 20; i++) pending_moves.push_back(random_move());
        @(posedge clk);
        hold_sink <= 1'b0;
        drain();

        // mirrored, crossed limits, zero spans, extremes
        set_all(2000, 0, -2000, 4095, 0, 4095, 1);
        for (int i = 0; i < 30; i++) pending_moves.push_back(random_move());
        drain();
        set_all(-4096, -4096, 4095, 0, 4095, 0, 0);
        for (int i = 0; i < 30; i++) pending_moves.push_back(random_move());
        drain();
        set_all(-4096, 4095, 4095, 0, 2047, 4095, 1);
        for (int i = 0; i < 30; i++) pending_moves.push_back(random_move());
        drain();
        set_all(-2356, 0, 2356, 500, 1500, 2500, 0);
        write_reg(3'd7, 123);
        for (int ph = 0; ph < 4; ph++)
        begin
            set_all($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 1));
            for (int i = 0; i < 60; i++) pending_moves.push_back(random_move());
            drain();
        end
        set_all(-2356, 0, 2356, 500, 1500, 2500, 0);
        for (int i = 0; i < 60; i++) pending_moves.push_back(random_move());
        drain();
        idle_on = 1'b0;
        for (int i = 0; i < 50; i++) pending_moves.push_back(random_move());
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> sim.f
rtl/smce_pkg.sv
rtl/smce_ram.sv
rtl/smce_div.sv
rtl/smce_dp.sv
rtl/smce_ctrl.sv
rtl/servo_move_command_encoder.sv
tb/servo_move_command_encoder_tb.sv
